/* rtl/lrs_pkg.sv */
package lrs_pkg;

    localparam int STEPS_BITS = 18;
    localparam logic [STEPS_BITS-1:0] RAMP_STEPS_RESET = 18'd4800;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_SET  = 2'd1,
        CMD_JUMP = 2'd2
    } t_cmd;

endpackage

/* rtl/lrs_div.sv */
module lrs_div #(
    parameter int QUOT_BITS = 41
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [QUOT_BITS-1:0]         i_dividend,
    input  logic        [lrs_pkg::STEPS_BITS-1:0] i_divisor,
    output logic                                o_done,
    output logic signed [QUOT_BITS-1:0]         o_quotient
);

    localparam int CNT_BITS = $clog2(QUOT_BITS + 1);
    localparam int SB       = lrs_pkg::STEPS_BITS;

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_BITS-1:0]  r_cnt;
    logic                 r_neg;
    logic [SB-1:0]        r_div;
    logic [SB-1:0]        r_rem;
    logic [QUOT_BITS-1:0] r_quot;

    logic [QUOT_BITS-1:0] w_mag;
    logic [SB:0]          w_rem_sh;
    logic [SB:0]          w_rem_sub;
    logic                 w_fits;

    // magnitude of the dividend, quotient is negated back at the end
    assign w_mag     = i_dividend[QUOT_BITS-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign w_rem_sh  = {r_rem, r_quot[QUOT_BITS-1]};
    assign w_fits    = (w_rem_sh >= {1'b0, r_div});
    assign w_rem_sub = w_rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= CNT_BITS'(QUOT_BITS);
                r_neg  <= i_dividend[QUOT_BITS-1];
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_quot <= w_mag;
            end else if (r_busy) begin
                r_rem  <= w_fits ? w_rem_sub[SB-1:0] : w_rem_sh[SB-1:0];
                r_quot <= {r_quot[QUOT_BITS-2:0], w_fits};
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_BITS'(1));
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? $signed(~r_quot + 1'b1) : $signed(r_quot);

endmodule

/* rtl/linear_ramp_smoother_unit.sv */
// tick, jump and set-target with zero ramp length: result registered in the cycle after the item
// set-target with nonzero ramp length: step computed by the serial divider, one quotient
// bit a cycle, then the result enters the output register from ST_FIN once it is free
// one item at a time; next item taken once the result can enter the output register
// synchronous active-low reset clears value, target, step and ramp counter,
// and loads ramp_steps with 4800
module linear_ramp_smoother_unit #(
    parameter int VALUE_BITS    = 24,
    parameter int FRACTION_BITS = 16,
    localparam int IN_DATA_W    = ((VALUE_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W   = ((VALUE_BITS + 1 + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lrs_pkg::STEPS_BITS-1:0] i_cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [IN_DATA_W-1:0]           s_axis_tdata,  // new_value
    input  logic [1:0]                     s_axis_tuser,  // cmd
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [OUT_DATA_W-1:0]          m_axis_tdata   // current_value, ramping
);

    localparam int ACC_BITS  = VALUE_BITS + FRACTION_BITS;
    localparam int STEP_BITS = ACC_BITS + 1;
    localparam int SB        = lrs_pkg::STEPS_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } t_state;

    t_state                      r_state;
    logic [SB-1:0]               r_ramp_steps;
    logic signed [ACC_BITS-1:0]  r_acc;
    logic signed [VALUE_BITS-1:0] r_target;
    logic signed [STEP_BITS-1:0] r_step;
    logic [SB-1:0]               r_steps_left;
    logic                        r_out_valid;
    logic [VALUE_BITS-1:0]       r_out_value;
    logic                        r_out_ramping;

    logic                        w_accept;
    logic                        w_out_free;
    logic                        w_out_load;
    logic signed [VALUE_BITS-1:0] w_new_value;
    logic signed [ACC_BITS-1:0]  w_new_acc;
    logic signed [ACC_BITS-1:0]  w_target_acc;
    logic signed [ACC_BITS-1:0]  w_tick_acc;
    logic signed [STEP_BITS-1:0] w_diff;
    logic                        w_div_start;
    logic                        w_div_done;
    logic signed [STEP_BITS-1:0] w_quot;
    lrs_pkg::t_cmd               w_cmd;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_cmd        = lrs_pkg::t_cmd'(s_axis_tuser);
    assign w_new_value  = $signed(s_axis_tdata[VALUE_BITS-1:0]);
    assign w_new_acc    = ACC_BITS'(w_new_value) <<< FRACTION_BITS;
    assign w_target_acc = ACC_BITS'(r_target) <<< FRACTION_BITS;
    assign w_tick_acc   = r_acc + r_step[ACC_BITS-1:0];
    assign w_diff       = STEP_BITS'(w_new_acc) - STEP_BITS'(r_acc);
    assign w_div_start  = w_accept && (w_cmd == lrs_pkg::CMD_SET) && (r_ramp_steps != '0);
    assign w_out_load   = (w_accept && !w_div_start) || ((r_state == ST_FIN) && w_out_free);

    lrs_div #(
        .QUOT_BITS (STEP_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_diff),
        .i_divisor  (r_ramp_steps),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_ramp_steps  <= lrs_pkg::RAMP_STEPS_RESET;
            r_acc         <= '0;
            r_target      <= '0;
            r_step        <= '0;
            r_steps_left  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ramp_steps <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (w_div_start) begin
                            r_target     <= w_new_value;
                            r_steps_left <= r_ramp_steps;
                            r_state      <= ST_DIV;
                        end else begin
                            unique case (w_cmd)
                                lrs_pkg::CMD_TICK: begin
                                    if (r_steps_left != '0) begin
                                        r_steps_left <= r_steps_left - 1'b1;
                                        if (r_steps_left == SB'(1)) begin
                                            r_acc         <= w_target_acc;
                                            r_out_value   <= r_target;
                                            r_out_ramping <= 1'b0;
                                        end else begin
                                            r_acc         <= w_tick_acc;
                                            r_out_value   <=
                                                w_tick_acc[ACC_BITS-1 -: VALUE_BITS];
                                            r_out_ramping <= 1'b1;
                                        end
                                    end else begin
                                        r_out_value   <= r_acc[ACC_BITS-1 -: VALUE_BITS];
                                        r_out_ramping <= 1'b0;
                                    end
                                end
                                lrs_pkg::CMD_SET,
                                lrs_pkg::CMD_JUMP: begin
                                    // zero ramp length behaves as a jump
                                    r_acc         <= w_new_acc;
                                    r_target      <= w_new_value;
                                    r_step        <= '0;
                                    r_steps_left  <= '0;
                                    r_out_value   <= w_new_value;
                                    r_out_ramping <= 1'b0;
                                end
                                default: begin
                                    r_out_value   <= r_acc[ACC_BITS-1 -: VALUE_BITS];
                                    r_out_ramping <= (r_steps_left != '0);
                                end
                            endcase
                        end
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_step  <= w_quot;
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_out_value   <= r_acc[ACC_BITS-1 -: VALUE_BITS];
                        r_out_ramping <= 1'b1;
                        r_state       <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'({r_out_ramping, r_out_value});

endmodule
